// ===== design/tadc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle classifier package
// Shared widths, constants, register codes and the arctangent table.
// ----------------------------------------------------------------------------
package tadc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ANGLE_W   = 17;
    localparam int DIR_W     = 3;
    localparam int DIFF_W    = 18;
    localparam int MUL_W     = 26;
    localparam int NUM_W     = 24;
    localparam int DEN_W     = 16;
    localparam int MAP_W     = 26;
    localparam int PRE_W     = MAP_W + 2;
    localparam int FRAC_W    = 32;
    localparam int CW        = 60;
    localparam int Z_W       = 32;
    localparam int ZT_W      = Z_W + 1;
    localparam int ANG_FRAC  = 22;
    localparam int TAB_LEN   = 24;
    localparam int T_W       = 31;
    localparam int PROD_W    = 38;
    localparam int HUND_W    = 16;
    localparam int SUM_W     = 18;

    localparam int MAP_LAT     = NUM_W + 3;
    localparam int CORDIC_XTRA = 4;
    localparam int OUT_LAT     = 2;

    localparam logic signed [MUL_W-1:0] MAP_SCALE = 26'sd180;
    localparam logic signed [MAP_W-1:0] MAP_BIAS  = 26'sd90;

    localparam logic signed [Z_W-1:0]  DEG90      = 32'sd377487360;
    localparam logic signed [Z_W-1:0]  DEG180     = 32'sd754974720;
    localparam logic signed [ZT_W-1:0] DEG180_EXT = 33'sd754974720;
    localparam logic signed [ZT_W-1:0] DEG360_EXT = 33'sd1509949440;
    localparam logic [PROD_W-1:0]      HUND_SCALE = 38'd100;
    localparam logic [PROD_W-1:0]      ROUND_HALF = 38'd2097152;

    localparam logic signed [Z_W-1:0] ATAN_TAB [TAB_LEN] = '{
        32'sd188743680, 32'sd111421900, 32'sd58872272, 32'sd29884485,
        32'sd15000234,  32'sd7507429,   32'sd3754631,  32'sd1877430,
        32'sd938729,    32'sd469366,    32'sd234683,   32'sd117342,
        32'sd58671,     32'sd29335,     32'sd14668,    32'sd7334,
        32'sd3667,      32'sd1833,      32'sd917,      32'sd458,
        32'sd229,       32'sd115,       32'sd57,       32'sd29
    };

    localparam logic signed [CFG_W-1:0] RST_SPAN_LOW  = 16'sd265;
    localparam logic signed [CFG_W-1:0] RST_SPAN_HIGH = 16'sd402;
    localparam logic [CFG_W-1:0]        RST_OFFSET_X  = 16'd35940;
    localparam logic [CFG_W-1:0]        RST_OFFSET_Y  = 16'd400;
    localparam logic [CFG_W-1:0]        RST_OFFSET_Z  = 16'd35000;

    localparam logic signed [SUM_W-1:0] UP_LO    = 18'sd3000;
    localparam logic signed [SUM_W-1:0] UP_HI    = 18'sd8000;
    localparam logic signed [SUM_W-1:0] DOWN_LO  = 18'sd26000;
    localparam logic signed [SUM_W-1:0] DOWN_HI  = 18'sd33000;
    localparam logic signed [SUM_W-1:0] LEFT_LO  = -18'sd34000;
    localparam logic signed [SUM_W-1:0] LEFT_HI  = -18'sd29000;
    localparam logic signed [SUM_W-1:0] RIGHT_LO = -18'sd9000;
    localparam logic signed [SUM_W-1:0] RIGHT_HI = -18'sd3000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPAN_LOW,
        CFG_SPAN_HIGH,
        CFG_OFFSET_X,
        CFG_OFFSET_Y,
        CFG_OFFSET_Z
    } t_cfg_reg;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN,
        DIR_LEFT,
        DIR_RIGHT
    } t_dir;

    typedef struct packed {
        logic             neg;
        logic [DEN_W-1:0] mag;
    } t_divisor;

endpackage

// ===== design/tilt_angle_direction_classifier_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle and direction classifier
// Maps three accelerometer axes, derives three tilt angles by CORDIC, applies
// the zero offsets and classifies the direction.
// ----------------------------------------------------------------------------
// While busy is low the block takes one sample in every clock cycle and gives
// its result, for one cycle, marked by o_valid, after the 24-step divider of
// the axis mapping and the CORDIC stages. busy is set by reset and cleared by
// the first clock edge without it, and results cannot be held off.
module tilt_angle_direction_classifier_unit #(
    parameter int SAMPLE_BITS   = 16,
    parameter int CORDIC_STAGES = 18
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tadc_pkg::SAMPLE_W-1:0]  i_accel_x,
    input  logic signed [tadc_pkg::SAMPLE_W-1:0]  i_accel_y,
    input  logic signed [tadc_pkg::SAMPLE_W-1:0]  i_accel_z,
    input  logic                                  i_cfg_we,
    input  logic [tadc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [tadc_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                  o_valid,
    output logic signed [tadc_pkg::ANGLE_W-1:0]   o_angle_x,
    output logic signed [tadc_pkg::ANGLE_W-1:0]   o_angle_y,
    output logic signed [tadc_pkg::ANGLE_W-1:0]   o_angle_z,
    output logic [tadc_pkg::DIR_W-1:0]            o_direction
);
    import tadc_pkg::*;

    localparam int LATENCY = MAP_LAT + CORDIC_STAGES + CORDIC_XTRA + OUT_LAT;

    logic signed [CFG_W-1:0]  r_span_low;
    logic signed [CFG_W-1:0]  r_span_high;
    logic [CFG_W-1:0]         r_offset_x;
    logic [CFG_W-1:0]         r_offset_y;
    logic [CFG_W-1:0]         r_offset_z;
    logic                     r_busy;
    t_divisor                 r_div;
    logic signed [DEN_W:0]    w_den;
    logic signed [DEN_W:0]    w_den_abs;
    logic                     w_accept;
    logic [2:0]               w_map_v;
    logic signed [MAP_W-1:0]  w_mx;
    logic signed [MAP_W-1:0]  w_my;
    logic signed [MAP_W-1:0]  w_mz;
    logic                     w_map_valid;
    logic [2:0]               w_cor_v;
    logic [HUND_W-1:0]        w_hx;
    logic [HUND_W-1:0]        w_hy;
    logic [HUND_W-1:0]        w_hz;
    logic signed [SUM_W-1:0]  r_ax;
    logic signed [SUM_W-1:0]  r_ay;
    logic signed [SUM_W-1:0]  r_az;
    logic                     r_s_valid;
    t_dir                     w_dir;
    t_dir                     r_dir;
    logic signed [ANGLE_W-1:0] r_out_x;
    logic signed [ANGLE_W-1:0] r_out_y;
    logic signed [ANGLE_W-1:0] r_out_z;
    logic                     r_out_valid;

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_span_low  <= RST_SPAN_LOW;
            r_span_high <= RST_SPAN_HIGH;
            r_offset_x  <= RST_OFFSET_X;
            r_offset_y  <= RST_OFFSET_Y;
            r_offset_z  <= RST_OFFSET_Z;
            r_busy      <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_SPAN_LOW: begin
                        r_span_low <= i_cfg_data;
                    end
                    CFG_SPAN_HIGH: begin
                        r_span_high <= i_cfg_data;
                    end
                    CFG_OFFSET_X: begin
                        r_offset_x <= i_cfg_data;
                    end
                    CFG_OFFSET_Y: begin
                        r_offset_y <= i_cfg_data;
                    end
                    CFG_OFFSET_Z: begin
                        r_offset_z <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign busy = r_busy;

    // A zero span divides by one.
    assign w_den     = (DEN_W+1)'(r_span_high) - (DEN_W+1)'(r_span_low);
    assign w_den_abs = w_den[DEN_W] ? -w_den : w_den;

    always_ff @(posedge i_clk) begin
        r_div.neg <= w_den[DEN_W];
        r_div.mag <= (w_den == '0) ? DEN_W'(1) : w_den_abs[DEN_W-1:0];
    end

    tadc_map #(.SAMPLE_BITS(SAMPLE_BITS)) u_map_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_accept),
        .i_sample(i_accel_x), .i_span_low(r_span_low), .i_div(r_div),
        .o_valid(w_map_v[0]), .o_map(w_mx)
    );

    tadc_map #(.SAMPLE_BITS(SAMPLE_BITS)) u_map_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_accept),
        .i_sample(i_accel_y), .i_span_low(r_span_low), .i_div(r_div),
        .o_valid(w_map_v[1]), .o_map(w_my)
    );

    tadc_map #(.SAMPLE_BITS(SAMPLE_BITS)) u_map_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_accept),
        .i_sample(i_accel_z), .i_span_low(r_span_low), .i_div(r_div),
        .o_valid(w_map_v[2]), .o_map(w_mz)
    );

    assign w_map_valid = &w_map_v;

    tadc_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_map_valid),
        .i_a(w_my), .i_b(w_mz), .o_valid(w_cor_v[0]), .o_hund(w_hx)
    );

    tadc_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_map_valid),
        .i_a(w_mx), .i_b(w_mz), .o_valid(w_cor_v[1]), .o_hund(w_hy)
    );

    tadc_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_map_valid),
        .i_a(w_my), .i_b(w_mx), .o_valid(w_cor_v[2]), .o_hund(w_hz)
    );

    always_ff @(posedge i_clk) begin
        r_ax <= $signed({2'b00, w_hx}) - $signed({2'b00, r_offset_x});
        r_ay <= $signed({2'b00, w_hy}) - $signed({2'b00, r_offset_y});
        r_az <= $signed({2'b00, w_hz}) - $signed({2'b00, r_offset_z});
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
        end else begin
            r_s_valid <= &w_cor_v;
        end
    end

    always_comb begin
        if (r_ay >= UP_LO && r_ay <= UP_HI) begin
            w_dir = DIR_UP;
        end else if (r_ay >= DOWN_LO && r_ay <= DOWN_HI) begin
            w_dir = DIR_DOWN;
        end else if (r_ax >= LEFT_LO && r_ax <= LEFT_HI) begin
            w_dir = DIR_LEFT;
        end else if (r_ax >= RIGHT_LO && r_ax <= RIGHT_HI) begin
            w_dir = DIR_RIGHT;
        end else begin
            w_dir = DIR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_x <= r_ax[ANGLE_W-1:0];
        r_out_y <= r_ay[ANGLE_W-1:0];
        r_out_z <= r_az[ANGLE_W-1:0];
        r_dir   <= w_dir;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s_valid;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_angle_x   = r_out_x;
    assign o_angle_y   = r_out_y;
    assign o_angle_z   = r_out_z;
    assign o_direction = r_dir;

    a_valid_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, LATENCY))
        else $error("result strobe without a matching input transfer");

    a_up_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_direction == DIR_UP) |->
            ($past(r_ay) >= UP_LO && $past(r_ay) <= UP_HI))
        else $error("up direction outside its window");

    a_left_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_direction == DIR_LEFT) |->
            ($past(r_ax) >= LEFT_LO && $past(r_ax) <= LEFT_HI
             && !($past(r_ay) >= UP_LO && $past(r_ay) <= UP_HI)))
        else $error("left direction given against the window order");

endmodule

// ===== design/tadc_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis mapping lane
// Maps one raw axis onto -90..90, for samples within the span, with a
// pipelined restoring divider that truncates toward zero.
// ----------------------------------------------------------------------------
module tadc_map #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic [tadc_pkg::SAMPLE_W-1:0]        i_sample,
    input  logic signed [tadc_pkg::CFG_W-1:0]    i_span_low,
    input  tadc_pkg::t_divisor                   i_div,
    output logic                                 o_valid,
    output logic signed [tadc_pkg::MAP_W-1:0]    o_map
);
    import tadc_pkg::*;

    localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;

    logic signed [SAMPLE_W-1:0]      w_sext;
    logic signed [MUL_W-1:0]         w_prod;
    logic signed [MUL_W-1:0]         w_abs;
    logic signed [MAP_W-1:0]         w_q;
    logic signed [DIFF_W-1:0]        r_diff;
    logic                            r_diff_valid;
    logic [DEN_W+NUM_W-1:0]          r_rq    [0:NUM_W];
    logic                            r_neg   [0:NUM_W];
    logic                            r_valid [0:NUM_W];
    logic signed [MAP_W-1:0]         r_map;
    logic                            r_map_valid;

    assign w_sext = $signed(i_sample << SHIFT) >>> SHIFT;
    assign w_prod = MUL_W'(r_diff) * MAP_SCALE;
    assign w_abs  = w_prod[MUL_W-1] ? -w_prod : w_prod;

    always_ff @(posedge i_clk) begin
        r_diff   <= DIFF_W'(w_sext) - DIFF_W'(i_span_low);
        r_rq[0]  <= {{DEN_W{1'b0}}, w_abs[NUM_W-1:0]};
        r_neg[0] <= w_prod[MUL_W-1];
        if (!i_rst_n) begin
            r_diff_valid <= 1'b0;
            r_valid[0]   <= 1'b0;
        end else begin
            r_diff_valid <= i_valid;
            r_valid[0]   <= r_diff_valid;
        end
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_div
        logic [DEN_W:0] w_cand;
        logic [DEN_W:0] w_sub;
        logic           w_take;

        assign w_cand = r_rq[k][DEN_W+NUM_W-1:NUM_W-1];
        assign w_take = (w_cand >= {1'b0, i_div.mag});
        assign w_sub  = w_cand - {1'b0, i_div.mag};

        always_ff @(posedge i_clk) begin
            r_rq[k+1]  <= {(w_take ? w_sub[DEN_W-1:0] : w_cand[DEN_W-1:0]),
                           r_rq[k][NUM_W-2:0], w_take};
            r_neg[k+1] <= r_neg[k];
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
        end
    end

    assign w_q = $signed({{(MAP_W-NUM_W){1'b0}}, r_rq[NUM_W][NUM_W-1:0]});

    always_ff @(posedge i_clk) begin
        r_map <= ((r_neg[NUM_W] ^ i_div.neg) ? -w_q : w_q) - MAP_BIAS;
        if (!i_rst_n) begin
            r_map_valid <= 1'b0;
        end else begin
            r_map_valid <= r_valid[NUM_W];
        end
    end

    assign o_valid = r_map_valid;
    assign o_map   = r_map;

endmodule

// ===== design/tadc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle CORDIC lane
// Pipelined vectoring CORDIC giving 180 + atan2(-a, -b) in hundredths of a
// degree, rounded half up.
// ----------------------------------------------------------------------------
module tadc_cordic #(
    parameter int CORDIC_STAGES = 18
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [tadc_pkg::MAP_W-1:0]    i_a,
    input  logic signed [tadc_pkg::MAP_W-1:0]    i_b,
    output logic                                 o_valid,
    output logic [tadc_pkg::HUND_W-1:0]          o_hund
);
    import tadc_pkg::*;

    logic signed [PRE_W-1:0] w_x0;
    logic signed [PRE_W-1:0] w_y0;
    logic signed [PRE_W-1:0] w_xp;
    logic signed [PRE_W-1:0] w_yp;
    logic signed [Z_W-1:0]   w_z0;
    logic                    w_skip;
    logic signed [ZT_W-1:0]  w_t;

    logic signed [CW-1:0]    r_x     [0:CORDIC_STAGES];
    logic signed [CW-1:0]    r_y     [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]   r_z     [0:CORDIC_STAGES];
    logic                    r_skip  [0:CORDIC_STAGES];
    logic                    r_valid [0:CORDIC_STAGES];
    logic [T_W-1:0]          r_t;
    logic [PROD_W-1:0]       r_p;
    logic [HUND_W-1:0]       r_h;
    logic                    r_t_valid;
    logic                    r_p_valid;
    logic                    r_h_valid;

    assign w_x0 = -PRE_W'(i_b);
    assign w_y0 = -PRE_W'(i_a);

    always_comb begin
        w_skip = 1'b1;
        w_z0   = '0;
        w_xp   = w_x0;
        w_yp   = w_y0;
        if (w_x0 == '0 && w_y0 == '0) begin
            w_z0 = '0;
        end else if (w_y0 == '0) begin
            w_z0 = (w_x0 > 0) ? '0 : DEG180;
        end else if (w_x0 == '0) begin
            w_z0 = (w_y0 > 0) ? DEG90 : -DEG90;
        end else begin
            w_skip = 1'b0;
            if (w_x0 < 0) begin
                w_z0 = (w_y0 >= 0) ? DEG180 : -DEG180;
                w_xp = -w_x0;
                w_yp = -w_y0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0]    <= CW'(w_xp) <<< FRAC_W;
        r_y[0]    <= CW'(w_yp) <<< FRAC_W;
        r_z[0]    <= w_z0;
        r_skip[0] <= w_skip;
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
    end

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
        logic signed [CW-1:0] w_xs;
        logic signed [CW-1:0] w_ys;

        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        always_ff @(posedge i_clk) begin
            r_skip[k+1] <= r_skip[k];
            if (r_skip[k]) begin
                r_x[k+1] <= r_x[k];
                r_y[k+1] <= r_y[k];
                r_z[k+1] <= r_z[k];
            end else if (r_y[k] > 0) begin
                r_x[k+1] <= r_x[k] + w_ys;
                r_y[k+1] <= r_y[k] - w_xs;
                r_z[k+1] <= r_z[k] + ATAN_TAB[k];
            end else begin
                r_x[k+1] <= r_x[k] - w_ys;
                r_y[k+1] <= r_y[k] + w_xs;
                r_z[k+1] <= r_z[k] - ATAN_TAB[k];
            end
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
        end
    end

    assign w_t = ZT_W'(r_z[CORDIC_STAGES]) + DEG180_EXT;

    always_ff @(posedge i_clk) begin
        if (w_t < 0) begin
            r_t <= '0;
        end else if (w_t > DEG360_EXT) begin
            r_t <= DEG360_EXT[T_W-1:0];
        end else begin
            r_t <= w_t[T_W-1:0];
        end
        r_p <= PROD_W'(r_t) * HUND_SCALE;
        r_h <= HUND_W'((r_p + ROUND_HALF) >> ANG_FRAC);
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else begin
            r_t_valid <= r_valid[CORDIC_STAGES];
            r_p_valid <= r_t_valid;
            r_h_valid <= r_p_valid;
        end
    end

    assign o_valid = r_h_valid;
    assign o_hund  = r_h;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt angle classifier testbench
// Streams accelerometer samples through the classifier under several span and
// offset settings. Each transfer is predicted by an independent fixed point
// model of the axis mapping, the CORDIC tilt angles and the direction windows,
// and every result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
    import tadc_pkg::*;

    localparam int STAGES = 18;
    localparam int FRAC   = 22;

    typedef struct {
        logic signed [SAMPLE_W-1:0] ax, ay, az;
    } t_sample;

    typedef struct {
        logic signed [ANGLE_W-1:0] ang_x, ang_y, ang_z;
        t_dir                      dir;
    } t_tilt;

    localparam longint ATAN_DEG [24] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [SAMPLE_W-1:0] i_accel_x = '0, i_accel_y = '0, i_accel_z = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic signed [ANGLE_W-1:0] o_angle_x, o_angle_y, o_angle_z;
    logic [DIR_W-1:0] o_direction;

    tilt_angle_direction_classifier_unit u_dut (.*);

    always #1 i_clk = ~i_clk;

    longint span_lo, span_hi, off_x, off_y, off_z;
    t_sample samples_pending[$];
    t_tilt   tilts_expected[$];
    t_sample cur_sample;
    int      gap_left;
    int      errors;
    int      tilts_checked;
    int      dir_seen[5];

    function automatic longint scale_axis(longint v);
        longint den;
        den = span_hi - span_lo;
        if (den == 0) den = 1;
        return (v - span_lo) * 180 / den - 90;
    endfunction

    function automatic longint tilt_hundredths(longint a, longint b);
        longint d180, d90, x, y, z, xs, ys, t;
        d180 = longint'(180) <<< FRAC;
        d90  = longint'(90) <<< FRAC;
        x = -b;
        y = -a;
        z = 0;
        if (x == 0 && y == 0) z = 0;
        else if (y == 0) z = (x > 0) ? 0 : d180;
        else if (x == 0) z = (y > 0) ? d90 : -d90;
        else begin
            if (x < 0) begin
                z = (y >= 0) ? d180 : -d180;
                x = -x;
                y = -y;
            end
            x = x <<< 32;
            y = y <<< 32;
            for (int i = 0; i < STAGES && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_DEG[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_DEG[i];
                end
            end
        end
        t = z + d180;
        if (t < 0) t = 0;
        if (t > 2 * d180) t = 2 * d180;
        return (t * 100 + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic t_tilt predict_tilt(t_sample s);
        t_tilt  r;
        longint mx, my, mz, ax, ay, az;
        mx = scale_axis(longint'(s.ax));
        my = scale_axis(longint'(s.ay));
        mz = scale_axis(longint'(s.az));
        ax = tilt_hundredths(my, mz) - off_x;
        ay = tilt_hundredths(mx, mz) - off_y;
        az = tilt_hundredths(my, mx) - off_z;
        if (ay >= 3000 && ay <= 8000) r.dir = DIR_UP;
        else if (ay >= 26000 && ay <= 33000) r.dir = DIR_DOWN;
        else if (ax >= -34000 && ax <= -29000) r.dir = DIR_LEFT;
        else if (ax >= -9000 && ax <= -3000) r.dir = DIR_RIGHT;
        else r.dir = DIR_NONE;
        r.ang_x = ax[ANGLE_W-1:0];
        r.ang_y = ay[ANGLE_W-1:0];
        r.ang_z = az[ANGLE_W-1:0];
        return r;
    endfunction

    // Driver: holds start until the transfer completes, then draws a gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else if (!(start && busy)) begin
            if (start) begin
                tilts_expected.push_back(predict_tilt(cur_sample));
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
            end
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                start <= 1'b0;
            end else if (samples_pending.size() != 0) begin
                cur_sample = samples_pending.pop_front();
                i_accel_x <= cur_sample.ax;
                i_accel_y <= cur_sample.ay;
                i_accel_z <= cur_sample.az;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_tilt e;
        if (i_rst_n && o_valid) begin
            if (tilts_expected.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = tilts_expected.pop_front();
                tilts_checked++;
                dir_seen[e.dir]++;
                if (o_angle_x !== e.ang_x) begin
                    $error("angle_x expected %0d got %0d", e.ang_x, o_angle_x);
                    errors++;
                end
                if (o_angle_y !== e.ang_y) begin
                    $error("angle_y expected %0d got %0d", e.ang_y, o_angle_y);
                    errors++;
                end
                if (o_angle_z !== e.ang_z) begin
                    $error("angle_z expected %0d got %0d", e.ang_z, o_angle_z);
                    errors++;
                end
                if (o_direction !== e.dir) begin
                    $error("direction expected %0d got %0d", e.dir, o_direction);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(t_cfg_reg r, logic [CFG_W-1:0] d);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= r;
        i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (r)
            CFG_SPAN_LOW:  span_lo = longint'($signed(d));
            CFG_SPAN_HIGH: span_hi = longint'($signed(d));
            CFG_OFFSET_X:  off_x = d;
            CFG_OFFSET_Y:  off_y = d;
            CFG_OFFSET_Z:  off_z = d;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [15:0] lo, logic [15:0] hi, logic [15:0] ox,
                           logic [15:0] oy, logic [15:0] oz);
        write_reg(CFG_SPAN_LOW, lo);
        write_reg(CFG_SPAN_HIGH, hi);
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_OFFSET_Z, oz);
    endtask

    function automatic logic [15:0] near_span();
        longint a, b, v;
        a = (span_lo < span_hi) ? span_lo : span_hi;
        b = (span_lo < span_hi) ? span_hi : span_lo;
        v = a - 40 + longint'($urandom_range(0, 32'(b - a + 80)));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] draw_axis();
        return ($urandom_range(0, 9) < 7) ? near_span() : 16'($urandom);
    endfunction

    task automatic push(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_sample s;
        s.ax = x;
        s.ay = y;
        s.az = z;
        samples_pending.push_back(s);
    endtask

    task automatic drain();
        wait (samples_pending.size() == 0 && !start && tilts_expected.size() == 0);
        repeat (40 + STAGES + 10) @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        tilts_checked = 0;
        span_lo = 265;
        span_hi = 402;
        off_x = 35940;
        off_y = 400;
        off_z = 35000;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: extremes, span ends, zero components and both zero.
        push(16'h0000, 16'h0000, 16'h0000);
        push(16'h7FFF, 16'h7FFF, 16'h7FFF);
        push(16'h8000, 16'h8000, 16'h8000);
        push(16'h7FFF, 16'h8000, 16'h7FFF);
        push(16'd265, 16'd402, 16'd265);
        push(16'd402, 16'd265, 16'd402);
        push(16'd334, 16'd334, 16'd334);
        push(16'd334, 16'd334, 16'd402);
        push(16'd334, 16'd334, 16'd265);
        push(16'd402, 16'd334, 16'd334);
        push(16'd265, 16'd334, 16'd334);
        push(16'd334, 16'd402, 16'd334);
        push(16'd334, 16'd265, 16'd334);
        push(16'd300, 16'd380, 16'd360);
        push(16'd380, 16'd300, 16'd290);
        for (int i = 0; i < 300; i++) push(draw_axis(), draw_axis(), draw_axis());
        drain();

        set_all(16'hC000, 16'h4000, 16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 320; i++) push(draw_axis(), draw_axis(), draw_axis());
        drain();

        set_all(16'd100, 16'd100, 16'd36000, 16'd36000, 16'd36000);
        push(16'd100, 16'd100, 16'd100);
        for (int i = 0; i < 300; i++) push(draw_axis(), draw_axis(), draw_axis());
        drain();

        set_all(16'd500, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 320; i++) push(draw_axis(), draw_axis(), draw_axis());
        drain();

        set_all(16'h8000, 16'h7FFF, 16'd18000, 16'd9000, 16'd27000);
        push(16'h8000, 16'h7FFF, 16'h0000);
        for (int i = 0; i < 320; i++) push(draw_axis(), draw_axis(), draw_axis());
        drain();

        $display("Checked %0d results over five register settings.", tilts_checked);
        $display("Directions none/up/down/left/right: %0d/%0d/%0d/%0d/%0d",
                 dir_seen[0], dir_seen[1], dir_seen[2], dir_seen[3], dir_seen[4]);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
